FILE: rtl/ssp_pkg.sv
// Package for the size string parser: widths, phase codes, character codes and decoders.
`default_nettype none

package ssp_pkg;

    localparam int CharW  = 8;
    localparam int SizeW  = 64;
    localparam int MagW   = 63;
    localparam int ShiftW = 6;
    localparam int PhaseW = 2;

    typedef logic [CharW-1:0]  char_t;
    typedef logic [SizeW-1:0]  size_t;
    typedef logic [MagW-1:0]   mag_t;
    typedef logic [ShiftW-1:0] shift_t;
    typedef logic [PhaseW-1:0] phase_t;

    // Parse phases
    localparam phase_t PH_SPACE  = 2'd0;
    localparam phase_t PH_DIGITS = 2'd1;
    localparam phase_t PH_STOP   = 2'd2;

    // Character codes
    localparam char_t CH_NUL   = 8'h00;
    localparam char_t CH_TAB   = 8'h09;
    localparam char_t CH_CR    = 8'h0D;
    localparam char_t CH_SPACE = 8'h20;
    localparam char_t CH_PLUS  = 8'h2B;
    localparam char_t CH_MINUS = 8'h2D;
    localparam char_t CH_ZERO  = 8'h30;
    localparam char_t CH_NINE  = 8'h39;

    // Suffix shift amounts
    localparam shift_t SH_NONE = 6'd0;
    localparam shift_t SH_KILO = 6'd10;
    localparam shift_t SH_MEGA = 6'd20;
    localparam shift_t SH_GIGA = 6'd30;
    localparam shift_t SH_TERA = 6'd40;
    localparam shift_t SH_PETA = 6'd50;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    function automatic shift_t suffix_bits(input char_t c);
        shift_t s;
        case (c)
            8'h50, 8'h70: s = SH_PETA;   // P p
            8'h54, 8'h74: s = SH_TERA;   // T t
            8'h47, 8'h67: s = SH_GIGA;   // G g
            8'h4D, 8'h6D: s = SH_MEGA;   // M m
            8'h4B, 8'h6B: s = SH_KILO;   // K k
            default:      s = SH_NONE;
        endcase
        return s;
    endfunction

    function automatic logic is_blank(input char_t c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(input char_t c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ssp_char_if.sv
// Channel carrying one string byte per transaction.
`default_nettype none

interface ssp_char_if;
    import ssp_pkg::*;

    logic  valid;
    logic  ready;
    char_t char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

`default_nettype wire

FILE: rtl/ssp_size_if.sv
// Channel carrying one parsed size and its status per transaction.
`default_nettype none

interface ssp_size_if;
    import ssp_pkg::*;

    logic  valid;
    logic  ready;
    size_t size_value;
    logic  status;

    modport source (output valid, output size_value, output status, input ready);
    modport sink   (input valid, input size_value, input status, output ready);
endinterface

`default_nettype wire

FILE: rtl/size_string_suffix_parser.sv
// Top level of the decimal size string parser with binary suffix.
`default_nettype none

// Parses a NUL-terminated decimal size string, one byte per transaction on
// `text`, with strtoll-like rules: leading white space is skipped, one
// optional sign is taken, then decimal digits; the character after the
// digits may be a K/M/G/T/P suffix (either case) that shifts the value left
// by 10/20/30/40/50 bits, modulo 2^64. All later bytes are ignored. The NUL
// byte produces exactly one transaction on `result`: the shifted size with
// status 0, or size 0 with status 1 when there were no digits, the magnitude
// exceeded 2^63-1, or the value was negative and nonzero. The parser then
// returns to its reset state for the next string. Throughput is one byte per
// clock cycle, sustained except for the stall below; a NUL byte passes
// through the input register, and its result is then held in the result
// register until it is taken. Each byte is worked by the x10 shift-add and
// overflow compare on the 63-bit accumulator. The input stage stalls
// only when a NUL is pending and the result register still holds an
// untaken result.
module size_string_suffix_parser (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ssp_char_if.sink    text,
    ssp_size_if.source  result
);
    import ssp_pkg::*;

    // Input register
    logic   in_valid_reg;
    char_t  in_char_reg;

    // Parse state
    phase_t phase_reg,    phase_next;
    logic   neg_reg,      neg_next;
    logic   digit_reg,    digit_next;
    logic   ovf_reg,      ovf_next;
    mag_t   acc_reg,      acc_next;
    shift_t shift_reg,    shift_next;

    // Result register
    logic   out_valid_reg;
    size_t  out_size_reg, out_size_next;
    logic   out_status_reg, out_status_next;

    logic   is_nul;
    logic   advance;
    logic   in_digits;
    logic   bad;
    logic [MagW+3:0] acc_x10;   // acc*10 + d, wide enough to catch overflow
    size_t  shifted;

    assign is_nul  = (in_char_reg == CH_NUL);
    // Input stage moves on unless a NUL would overwrite an untaken result
    assign advance = in_valid_reg && (!is_nul || !out_valid_reg || result.ready);
    assign text.ready = !in_valid_reg || advance;

    // A non-blank, non-sign byte in the white-space phase is handled as a digit-phase byte
    assign in_digits = (phase_reg == PH_DIGITS) ||
                       ((phase_reg == PH_SPACE) && !is_blank(in_char_reg) &&
                        (in_char_reg != CH_PLUS) && (in_char_reg != CH_MINUS));

    // acc*10 + digit as shift-add
    assign acc_x10 = {3'b000, acc_reg, 1'b0} + {1'b0, acc_reg, 3'b000}
                   + {{(MagW+4-4){1'b0}}, in_char_reg[3:0]};

    assign bad = !digit_reg || ovf_reg || (neg_reg && (acc_reg != '0));

    always_comb
    begin
        case (shift_reg)
            SH_KILO: shifted = {1'b0, acc_reg} << SH_KILO;
            SH_MEGA: shifted = {1'b0, acc_reg} << SH_MEGA;
            SH_GIGA: shifted = {1'b0, acc_reg} << SH_GIGA;
            SH_TERA: shifted = {1'b0, acc_reg} << SH_TERA;
            SH_PETA: shifted = {1'b0, acc_reg} << SH_PETA;
            default: shifted = {1'b0, acc_reg};
        endcase
    end

    always_comb
    begin
        phase_next      = phase_reg;
        neg_next        = neg_reg;
        digit_next      = digit_reg;
        ovf_next        = ovf_reg;
        acc_next        = acc_reg;
        shift_next      = shift_reg;
        out_size_next   = bad ? '0 : shifted;
        out_status_next = bad ? STATUS_INVALID : STATUS_OK;

        if (advance)
        begin
            if (is_nul)
            begin
                phase_next = PH_SPACE;
                neg_next   = 1'b0;
                digit_next = 1'b0;
                ovf_next   = 1'b0;
                acc_next   = '0;
                shift_next = SH_NONE;
            end
            else if (in_digits)
            begin
                if (is_digit(in_char_reg))
                begin
                    phase_next = PH_DIGITS;
                    digit_next = 1'b1;
                    if (!ovf_reg)
                    begin
                        if (acc_x10[MagW+3:MagW] != '0)
                            ovf_next = 1'b1;   // accumulator holds its last value
                        else
                            acc_next = acc_x10[MagW-1:0];
                    end
                end
                else
                begin
                    if (digit_reg)
                        shift_next = suffix_bits(in_char_reg);
                    phase_next = PH_STOP;
                end
            end
            else if (phase_reg == PH_SPACE && !is_blank(in_char_reg))
            begin
                // sign byte
                phase_next = PH_DIGITS;
                if (in_char_reg == CH_MINUS)
                    neg_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_SPACE;
            neg_reg       <= 1'b0;
            digit_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            acc_reg       <= '0;
            shift_reg     <= SH_NONE;
        end
        else
        begin
            if (text.ready)
                in_valid_reg <= text.valid;
            if (advance && is_nul)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            digit_reg <= digit_next;
            ovf_reg   <= ovf_next;
            acc_reg   <= acc_next;
            shift_reg <= shift_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (text.ready && text.valid)
            in_char_reg <= text.char_code;
        if (advance && is_nul)
        begin
            out_size_reg   <= out_size_next;
            out_status_reg <= out_status_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.size_value = out_size_reg;
    assign result.status     = out_status_reg;

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the decimal size string parser.
`timescale 1ns / 1ps

// Strings go in one byte per transaction, each closed by a NUL. An in-bench
// parser follows every accepted byte and queues the size and status that the
// NUL should produce. Each result transaction is checked against the oldest
// queued entry. A short table of hand-picked strings runs first. Random
// strings follow: mostly well-formed numbers with random content, plus noise
// and broken strings. Both sides stall at random, with quiet stretches between.
module tb_top;
    import ssp_pkg::*;

    typedef struct packed {
        size_t value;
        logic  status;
    } size_res_t;

    typedef struct {
        string     text;
        bit        typed;     // hand-written expectation replaces the prediction
        size_t     value;
        logic      status;
    } dir_row_t;

    localparam size_t MAG_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int    RANDOM_ITEMS = 1510;
    localparam int    DRAIN_CYCLES = 8;     // extra wait after the last result is checked

    logic clk;
    logic rst_n;

    ssp_char_if text_ch ();
    ssp_size_if size_ch ();

    size_string_suffix_parser dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .result (size_ch)
    );

    // Parser state as seen by the bench
    phase_t    sp_phase;
    logic      sp_neg;
    logic      sp_digits;
    logic      sp_ovf;
    mag_t      sp_mag;
    shift_t    sp_shift;

    size_res_t pending_sizes[$];
    int        errors;
    bit        no_idle;      // quiet stretch: neither side stalls

    // Hand-written expectation for the NUL that is on the bus, if any
    bit        fixed_on;
    size_res_t fixed_res;

    char_t     line_buf[$];
    dir_row_t  dir_rows[$];

    // ---------------------------------------------------------------------
    // Clock and reset
    // ---------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------
    function automatic shift_t shift_of(input char_t c);
        case (c)
            "K", "k": return SH_KILO;
            "M", "m": return SH_MEGA;
            "G", "g": return SH_GIGA;
            "T", "t": return SH_TERA;
            "P", "p": return SH_PETA;
            default:  return SH_NONE;
        endcase
    endfunction

    task automatic clear_parse();
        sp_phase  = PH_SPACE;
        sp_neg    = 1'b0;
        sp_digits = 1'b0;
        sp_ovf    = 1'b0;
        sp_mag    = '0;
        sp_shift  = SH_NONE;
    endtask

    // Advance the parser by one accepted byte; a NUL queues its result.
    task automatic parse_char(input char_t c);
        size_res_t r;
        size_t     d;
        logic      bad;
        if (c == CH_NUL)
        begin
            bad = !sp_digits || sp_ovf || (sp_neg && sp_mag != '0);
            r.status = bad ? STATUS_INVALID : STATUS_OK;
            r.value  = bad ? '0 : (size_t'(sp_mag) << sp_shift);
            pending_sizes.push_back(fixed_on ? fixed_res : r);
            clear_parse();
            return;
        end
        if (sp_phase == PH_SPACE)
        begin
            if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
                return;
            sp_phase = PH_DIGITS;
            if (c == CH_PLUS)
                return;
            if (c == CH_MINUS)
            begin
                sp_neg = 1'b1;
                return;
            end
        end
        if (sp_phase == PH_DIGITS)
        begin
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                d = size_t'(c - CH_ZERO);
                sp_digits = 1'b1;
                // Once the magnitude overflows, later digits are dropped
                if (!sp_ovf)
                begin
                    if (size_t'(sp_mag) > (MAG_LIMIT - d) / 10)
                        sp_ovf = 1'b1;
                    else
                        sp_mag = mag_t'(size_t'(sp_mag) * 10 + d);
                end
            end
            else
            begin
                if (sp_digits)
                    sp_shift = shift_of(c);
                sp_phase = PH_STOP;
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Monitor: results are checked before the byte of the same edge is
    // parsed; a NUL's result cannot leave in the cycle it is accepted.
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        size_res_t want;
        if (rst_n)
        begin
            if (size_ch.valid && size_ch.ready)
            begin
                if (pending_sizes.size() == 0)
                begin
                    $display("%0t: result with nothing pending: size %h status %0b",
                             $time, size_ch.size_value, size_ch.status);
                    errors++;
                end
                else
                begin
                    want = pending_sizes.pop_front();
                    if (size_ch.size_value !== want.value)
                    begin
                        $display("%0t: size_value expected %h actual %h",
                                 $time, want.value, size_ch.size_value);
                        errors++;
                    end
                    if (size_ch.status !== want.status)
                    begin
                        $display("%0t: status expected %0b actual %0b",
                                 $time, want.status, size_ch.status);
                        errors++;
                    end
                end
            end
            if (text_ch.valid && text_ch.ready)
                parse_char(text_ch.char_code);
        end
    end

    // ---------------------------------------------------------------------
    // Result side: random stall before each transaction
    // ---------------------------------------------------------------------
    initial
    begin : result_sink
        int stall;
        size_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                size_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            size_ch.ready = 1'b1;
            do @(posedge clk); while (!size_ch.valid);
        end
    end

    // ---------------------------------------------------------------------
    // Byte side. Entered and left at a falling edge; valid stays high
    // across back-to-back transactions.
    // ---------------------------------------------------------------------
    task automatic send_char(input char_t c);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            text_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        text_ch.valid     = 1'b1;
        text_ch.char_code = c;
        do @(posedge clk); while (!text_ch.ready);
        @(negedge clk);
    endtask

    // Sends line_buf followed by the terminating NUL
    task automatic send_line();
        foreach (line_buf[i])
            send_char(line_buf[i]);
        send_char(CH_NUL);
    endtask

    task automatic add_row(input string s, input bit typed, input size_t v, input logic st);
        dir_row_t row;
        row.text   = s;
        row.typed  = typed;
        row.value  = v;
        row.status = st;
        dir_rows.push_back(row);
    endtask

    // Random string: mostly a well-formed number, sometimes noise or a
    // broken sign sequence. Returns the byte count, NUL included.
    task automatic build_random_line(output int live);
        int    kind;
        int    n;
        char_t blanks[6];
        char_t sfx[10];
        string boundary;
        blanks = '{CH_SPACE, CH_TAB, 8'h0A, 8'h0B, 8'h0C, CH_CR};
        sfx    = '{"K", "k", "M", "m", "G", "g", "T", "t", "P", "p"};
        boundary = "922337203685477580";
        line_buf.delete();
        kind = $urandom_range(0, 9);
        if (kind == 8)
        begin
            // noise: any non-NUL bytes
            n = $urandom_range(0, 6);
            repeat (n) line_buf.push_back(char_t'($urandom_range(1, 255)));
            live = n + 1;
            return;
        end
        if (kind == 9)
        begin
            // broken: signs and blanks mixed in before the digits
            repeat ($urandom_range(1, 3))
            begin
                case ($urandom_range(0, 2))
                    0: line_buf.push_back(CH_PLUS);
                    1: line_buf.push_back(CH_MINUS);
                    default: line_buf.push_back(blanks[$urandom_range(0, 5)]);
                endcase
            end
            repeat ($urandom_range(0, 3))
                line_buf.push_back(CH_ZERO + char_t'($urandom_range(0, 9)));
            live = line_buf.size() + 1;
            return;
        end
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0)
            line_buf.push_back(blanks[$urandom_range(0, 5)]);
        case ($urandom_range(0, 3))
            0: line_buf.push_back(CH_PLUS);
            1: line_buf.push_back(CH_MINUS);
            default: ;
        endcase
        case ($urandom_range(0, 9))
            0:
            begin
                // right on the overflow boundary
                for (int i = 0; i < boundary.len(); i++)
                    line_buf.push_back(boundary[i]);
                line_buf.push_back(CH_ZERO + char_t'($urandom_range(0, 9)));
            end
            1:  repeat ($urandom_range(1, 3)) line_buf.push_back(CH_ZERO);
            2:  repeat ($urandom_range(15, 22))
                    line_buf.push_back(CH_ZERO + char_t'($urandom_range(0, 9)));
            default:
                repeat ($urandom_range(1, 7))
                    line_buf.push_back(CH_ZERO + char_t'($urandom_range(0, 9)));
        endcase
        case ($urandom_range(0, 3))
            0: ;
            1: line_buf.push_back(char_t'($urandom_range(1, 255)));
            default: line_buf.push_back(sfx[$urandom_range(0, 9)]);
        endcase
        // trailing random bytes
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0)
            line_buf.push_back(char_t'($urandom_range(1, 255)));
        live = line_buf.size() + 1;
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial
    begin : stimulus
        int sent;
        int live;
        int lines;
        string s;

        errors            = 0;
        no_idle           = 1'b0;
        fixed_on          = 1'b0;
        fixed_res         = '0;
        text_ch.valid     = 1'b0;
        text_ch.char_code = CH_NUL;
        clear_parse();
        rst_n = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed strings; typed rows carry an expectation read straight off the spec
        add_row("",                     1, '0,                 STATUS_INVALID);
        add_row("0",                    1, '0,                 STATUS_OK);
        add_row("9223372036854775807",  1, MAG_LIMIT,          STATUS_OK);
        add_row("9223372036854775808",  1, '0,                 STATUS_INVALID);
        add_row("-0",                   1, '0,                 STATUS_OK);
        add_row("-5",                   1, '0,                 STATUS_INVALID);
        add_row("+",                    1, '0,                 STATUS_INVALID);
        add_row("- 5",                  1, '0,                 STATUS_INVALID);
        add_row("abc",                  1, '0,                 STATUS_INVALID);
        add_row("\t\n\013\014\r 42",    1, 64'd42,             STATUS_OK);
        add_row("+7",                   1, 64'd7,              STATUS_OK);
        add_row("1k",                   1, 64'd1 << 10,        STATUS_OK);
        add_row("1K",                   1, 64'd1 << 10,        STATUS_OK);
        add_row("1m",                   1, 64'd1 << 20,        STATUS_OK);
        add_row("1M",                   1, 64'd1 << 20,        STATUS_OK);
        add_row("1g",                   1, 64'd1 << 30,        STATUS_OK);
        add_row("1G",                   1, 64'd1 << 30,        STATUS_OK);
        add_row("1t",                   1, 64'd1 << 40,        STATUS_OK);
        add_row("1T",                   1, 64'd1 << 40,        STATUS_OK);
        add_row("1p",                   1, 64'd1 << 50,        STATUS_OK);
        add_row("1P",                   1, 64'd1 << 50,        STATUS_OK);
        add_row("16384P",               0, '0,                 STATUS_OK);
        add_row("9223372036854775807K", 0, '0,                 STATUS_OK);
        add_row("12x34",                0, '0,                 STATUS_OK);
        add_row("7\377\200",            0, '0,                 STATUS_OK);

        foreach (dir_rows[r])
        begin
            s = dir_rows[r].text;
            line_buf.delete();
            for (int i = 0; i < s.len(); i++)
                line_buf.push_back(s[i]);
            foreach (line_buf[i])
                send_char(line_buf[i]);
            // the override is read when the NUL is accepted
            fixed_on         = dir_rows[r].typed;
            fixed_res.value  = dir_rows[r].value;
            fixed_res.status = dir_rows[r].status;
            send_char(CH_NUL);
            fixed_on = 1'b0;
        end

        // Random strings
        sent  = 0;
        lines = 0;
        while (sent < RANDOM_ITEMS)
        begin
            // quiet stretch for a few strings out of every forty
            no_idle = (lines % 40) < 6;
            if (lines % 70 == 69)
            begin
                // hold the byte side until every result is out
                text_ch.valid = 1'b0;
                while (pending_sizes.size() != 0) @(negedge clk);
            end
            build_random_line(live);
            send_line();
            sent += live;
            lines++;
        end

        text_ch.valid = 1'b0;
        no_idle       = 1'b0;
        while (pending_sizes.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
